>>> design/hsc_pkg.sv
package hsc_pkg;

    localparam int CH_W  = 8;
    localparam int LEN_W = 7;

    // Character codes
    localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CH_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CH_W-1:0] CH_HYPHEN = 8'h2D;

    // Label length limits
    localparam logic [LEN_W-1:0] MAX_LABEL_RESET = 7'd63;
    localparam logic [LEN_W-1:0] LABEL_SAT       = 7'h7F;

    // Class of one character
    typedef struct packed {
        logic is_term;
        logic is_letter;
        logic is_digit;
        logic is_hyphen;
        logic is_dot;
    } t_char_class;

endpackage

>>> design/hsc_if.sv
interface hsc_ch_if import hsc_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface hsc_verdict_if;
    logic valid;
    logic ready;
    logic name_valid;

    modport source (output valid, output name_valid, input ready);
    modport sink   (input valid, input name_valid, output ready);
endinterface

interface hsc_cfg_if import hsc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] label_cap;

    modport source (output valid, output label_cap, input ready);
    modport sink   (input valid, input label_cap, output ready);
endinterface

>>> design/hsc_char_class.sv
module hsc_char_class import hsc_pkg::*; (
    input  logic [CH_W-1:0] i_ch,
    output t_char_class     o_class
);

    // Decode the character into its syntax classes
    always_comb begin
        o_class.is_term   = (i_ch == CH_NUL) || (i_ch == CH_LF);
        o_class.is_letter = ((i_ch >= 8'h61) && (i_ch <= 8'h7A)) ||
                            ((i_ch >= 8'h41) && (i_ch <= 8'h5A));
        o_class.is_digit  = (i_ch >= 8'h30) && (i_ch <= 8'h39);
        o_class.is_hyphen = (i_ch == CH_HYPHEN);
        o_class.is_dot    = (i_ch == CH_DOT);
    end

endmodule

>>> design/hsc_name_check.sv
module hsc_name_check import hsc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  t_char_class      i_class,
    input  logic [LEN_W-1:0] i_label_cap,
    output logic             o_name_valid
);

    logic             r_at_start, n_at_start;
    logic             r_after_dot, n_after_dot;
    logic [LEN_W-1:0] r_label_len, n_label_len;
    logic             r_last_alnum, n_last_alnum;
    logic             r_failed, n_failed;
    logic             too_long;

    assign too_long = (r_label_len > i_label_cap);

    // Verdict for a terminator in the current state
    assign o_name_valid = !r_at_start && !r_failed && !r_after_dot && !too_long &&
                          r_last_alnum;

    // Next name state for one character
    always_comb begin
        n_at_start   = r_at_start;
        n_after_dot  = r_after_dot;
        n_label_len  = r_label_len;
        n_last_alnum = r_last_alnum;
        n_failed     = r_failed;
        if (i_class.is_term) begin
            n_at_start   = 1'b1;
            n_after_dot  = 1'b0;
            n_label_len  = '0;
            n_last_alnum = 1'b0;
            n_failed     = 1'b0;
        end else if (r_failed) begin
            n_failed = 1'b1;
        end else if (r_at_start || r_after_dot) begin
            if (!i_class.is_letter) begin
                n_failed = 1'b1;
            end else begin
                n_at_start   = 1'b0;
                n_after_dot  = 1'b0;
                n_label_len  = LEN_W'(1);
                n_last_alnum = 1'b1;
            end
        end else if (i_class.is_dot) begin
            if ((r_label_len == '0) || too_long) begin
                n_failed = 1'b1;
            end else begin
                n_after_dot  = 1'b1;
                n_last_alnum = 1'b0;
            end
        end else if (i_class.is_letter || i_class.is_digit || i_class.is_hyphen) begin
            if (r_label_len != LABEL_SAT) begin
                n_label_len = r_label_len + LEN_W'(1);
            end
            n_last_alnum = !i_class.is_hyphen;
        end else begin
            n_failed = 1'b1;
        end
    end

    // Advance the state on each processed character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start   <= 1'b1;
            r_after_dot  <= 1'b0;
            r_label_len  <= '0;
            r_last_alnum <= 1'b0;
            r_failed     <= 1'b0;
        end else if (i_step) begin
            r_at_start   <= n_at_start;
            r_after_dot  <= n_after_dot;
            r_label_len  <= n_label_len;
            r_last_alnum <= n_last_alnum;
            r_failed     <= n_failed;
        end
    end

    // A terminator always restarts the name
    a_term_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_class.is_term) |=> (r_at_start && !r_failed && r_label_len == '0))
        else $error("name state not restarted after terminator");

    // Once past the first letter, the label count is never zero
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_at_start |-> (r_label_len != '0))
        else $error("label count zero inside a name");

    // A pending dot implies the name has started
    a_dot_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_after_dot |-> !r_at_start)
        else $error("dot pending at start of name");

    // A failed name stays failed until its terminator
    a_fail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_failed && !(i_step && i_class.is_term)) |=> r_failed)
        else $error("failure cleared before terminator");

endmodule

>>> design/hostname_syntax_checker_top.sv
// Hostname syntax checker: one character per transfer, one verdict per name.
// Terminator path: input register, then result register once it is processed.
// One character per cycle unless stalled; name state is registered per character.
// The character input stalls only when a verdict is due and the output is full.
// Reset (i_rst_n low, synchronous): name state to start, label cap to 63,
// both pipeline registers empty.
module hostname_syntax_checker_top import hsc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    hsc_ch_if.sink               i_ch,
    hsc_cfg_if.sink              i_cfg,
    hsc_verdict_if.source        o_res
);

    logic             r_s1_valid;
    logic [CH_W-1:0]  r_s1_ch;
    logic [LEN_W-1:0] r_label_cap;
    logic             r_out_valid;
    logic             r_out_name_valid;
    t_char_class      s1_class;
    logic             s1_go;
    logic             name_ok;

    // Configuration register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_cap <= MAX_LABEL_RESET;
        end else if (i_cfg.valid) begin
            r_label_cap <= i_cfg.label_cap;
        end
    end

    // Decode the registered character
    hsc_char_class u_class (
        .i_ch    (r_s1_ch),
        .o_class (s1_class)
    );

    // Process a character unless its verdict would find the output full
    assign s1_go      = r_s1_valid && (!s1_class.is_term || !r_out_valid || o_res.ready);
    assign i_ch.ready = !r_s1_valid || s1_go;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_ch.ready) begin
            r_s1_valid <= i_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ch.valid && i_ch.ready) begin
            r_s1_ch <= i_ch.ch;
        end
    end

    // Name state and verdict
    hsc_name_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (s1_go),
        .i_class      (s1_class),
        .i_label_cap  (r_label_cap),
        .o_name_valid (name_ok)
    );

    // Result register: load on terminator, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && s1_class.is_term) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_class.is_term) begin
            r_out_name_valid <= name_ok;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.name_valid = r_out_name_valid;

endmodule
